FILE: hdl/fal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fal_pkg
// Shared widths, request codes and sequencer states of the frame allocator.
// ----------------------------------------------------------------------------
package fal_pkg;

    localparam int FAL_NUM_FRAMES = 32;

    localparam int CFG_W   = 6;
    localparam int REQ_W   = 2;
    localparam int IDX_W   = 5;
    localparam int PID_W   = 8;
    localparam int PAGE_W  = 12;
    localparam int STAMP_W = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TOUCH = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_RDMETA = 6'b001000,
        S_EVWR   = 6'b010000,
        S_PUSH   = 6'b100000
    } t_state;

endpackage

FILE: hdl/frame_allocator_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_allocator_lru
// Physical frame table with lowest-free allocation and LRU eviction.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one request word: allocate,
// free or touch. Output channel (o_out_valid / i_out_ready) returns exactly
// one result word per request. The config channel (i_cfg_valid, always
// ready) sets the number of frames managed; write it only while idle.
// A single scan pointer walks the frame table one frame per cycle, checking
// the used bit and feeding one stamp comparator through the registered read
// port of the stamp memory. The block takes one request at a time and is
// ready only in its idle state.
// Free and touch go from idle straight to the push state; allocate scans
// for the lowest free frame and, when every managed frame is taken, steps
// through scan, compare drain, metadata read and eviction write before push.
// A finished result waits in the output register while the receiver
// stalls; the next request is already accepted and waits for the slot.
// Reset (synchronous, active low) marks every frame free and sets the frame
// count to 32; frame owner, page and stamp memories are not cleared.
// ----------------------------------------------------------------------------
module frame_allocator_lru #(
    parameter int NUM_FRAMES = fal_pkg::FAL_NUM_FRAMES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fal_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [fal_pkg::REQ_W-1:0]    i_req_type,
    input  logic [fal_pkg::IDX_W-1:0]    i_frame_index,
    input  logic [fal_pkg::PID_W-1:0]    i_owner_pid,
    input  logic [fal_pkg::PAGE_W-1:0]   i_virtual_page,
    input  logic [fal_pkg::STAMP_W-1:0]  i_time_stamp,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [fal_pkg::IDX_W-1:0]    o_result_frame,
    output logic                         o_evicted,
    output logic [fal_pkg::PID_W-1:0]    o_evicted_pid,
    output logic [fal_pkg::PAGE_W-1:0]   o_evicted_page
);
    import fal_pkg::*;

    localparam int FW     = $clog2(NUM_FRAMES);
    localparam int CW     = $clog2(NUM_FRAMES + 1);
    localparam int AW     = (CW > CFG_W) ? CW : CFG_W;
    localparam int IW     = (FW > IDX_W) ? FW : IDX_W;
    localparam int META_W = PID_W + PAGE_W;

    t_state                 r_state, n_state;
    logic [CFG_W-1:0]       r_cfg;
    logic [NUM_FRAMES-1:0]  r_used, n_used;
    logic [FW-1:0]          r_ptr, n_ptr;

    logic                   r_q_vld;
    logic [FW-1:0]          r_q_idx;
    logic [STAMP_W-1:0]     r_stamp_q;
    logic [STAMP_W-1:0]     r_best;
    logic [FW-1:0]          r_victim;
    logic [META_W-1:0]      r_meta_q;

    logic [PID_W-1:0]       r_req_pid;
    logic [PAGE_W-1:0]      r_req_page;
    logic [STAMP_W-1:0]     r_req_stamp;

    logic [IDX_W-1:0]       r_res_frame, n_res_frame;
    logic                   r_res_ev, n_res_ev;
    logic [PID_W-1:0]       r_res_pid, n_res_pid;
    logic [PAGE_W-1:0]      r_res_page, n_res_page;

    logic                   r_out_valid;
    logic [IDX_W-1:0]       r_out_frame;
    logic                   r_out_ev;
    logic [PID_W-1:0]       r_out_pid;
    logic [PAGE_W-1:0]      r_out_page;

    logic [STAMP_W-1:0]     r_stamp_mem [NUM_FRAMES];
    logic [META_W-1:0]      r_meta_mem  [NUM_FRAMES];

    logic                   in_acc;
    logic                   out_free;
    logic [AW-1:0]          cfg_ext;
    logic [FW-1:0]          n_last;
    logic                   in_range;
    logic [FW-1:0]          idx_f;
    logic                   stamp_we;
    logic                   meta_we;
    logic [FW-1:0]          waddr;
    logic [STAMP_W-1:0]     wstamp;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Effective frame count minus one: zero counts as one, clip at table size
    assign cfg_ext = AW'(r_cfg);
    always_comb begin
        if (cfg_ext == '0) begin
            n_last = '0;
        end else if (cfg_ext > AW'(NUM_FRAMES)) begin
            n_last = FW'(NUM_FRAMES - 1);
        end else begin
            n_last = FW'(cfg_ext - AW'(1));
        end
    end

    assign in_range = IW'(i_frame_index) <= IW'(n_last);
    assign idx_f    = FW'(i_frame_index);

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_used      = r_used;
        n_res_frame = r_res_frame;
        n_res_ev    = r_res_ev;
        n_res_pid   = r_res_pid;
        n_res_page  = r_res_page;
        stamp_we    = 1'b0;
        meta_we     = 1'b0;
        waddr       = r_ptr;
        wstamp      = r_req_stamp;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ptr = '0;
                    if (i_req_type == REQ_ALLOC) begin
                        n_state = S_SCAN;
                    end else begin
                        // Free, touch and unknown codes all echo the index
                        n_state     = S_PUSH;
                        n_res_frame = i_frame_index;
                        n_res_ev    = 1'b0;
                        n_res_pid   = '0;
                        n_res_page  = '0;
                        case (i_req_type)
                            REQ_FREE: begin
                                if (in_range) begin
                                    n_used[idx_f] = 1'b0;
                                end
                            end
                            REQ_TOUCH: begin
                                if (in_range) begin
                                    stamp_we = 1'b1;
                                    waddr    = idx_f;
                                    wstamp   = i_time_stamp;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_SCAN: begin
                if (!r_used[r_ptr]) begin
                    // First free frame: take it and drop the running minimum
                    n_used[r_ptr] = 1'b1;
                    stamp_we      = 1'b1;
                    meta_we       = 1'b1;
                    waddr         = r_ptr;
                    n_res_frame   = IDX_W'(r_ptr);
                    n_res_ev      = 1'b0;
                    n_res_pid     = '0;
                    n_res_page    = '0;
                    n_state       = S_PUSH;
                end else if (r_ptr == n_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = r_ptr + FW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_RDMETA;
            end
            S_RDMETA: begin
                n_state = S_EVWR;
            end
            S_EVWR: begin
                stamp_we    = 1'b1;
                meta_we     = 1'b1;
                waddr       = r_victim;
                n_res_frame = IDX_W'(r_victim);
                n_res_ev    = 1'b1;
                n_res_pid   = r_meta_q[META_W-1:PAGE_W];
                n_res_page  = r_meta_q[PAGE_W-1:0];
                n_state     = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_used      <= '0;
            r_q_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_q_vld <= (r_state == S_SCAN) && r_used[r_ptr];
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (r_state == S_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_q_idx     <= r_ptr;
        r_res_frame <= n_res_frame;
        r_res_ev    <= n_res_ev;
        r_res_pid   <= n_res_pid;
        r_res_page  <= n_res_page;
        if (in_acc) begin
            r_req_pid   <= i_owner_pid;
            r_req_page  <= i_virtual_page;
            r_req_stamp <= i_time_stamp;
        end
        // Shared comparator: strictly smaller wins, so ties keep the lower index
        if (r_q_vld && (r_q_idx == '0 || r_stamp_q < r_best)) begin
            r_best   <= r_stamp_q;
            r_victim <= r_q_idx;
        end
        if (r_state == S_PUSH && out_free) begin
            r_out_frame <= r_res_frame;
            r_out_ev    <= r_res_ev;
            r_out_pid   <= r_res_pid;
            r_out_page  <= r_res_page;
        end
    end

    // Frame memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (stamp_we) begin
            r_stamp_mem[waddr] <= wstamp;
        end
        r_stamp_q <= r_stamp_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[waddr] <= {r_req_pid, r_req_page};
        end
        r_meta_q <= r_meta_mem[r_victim];
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_frame = r_out_frame;
    assign o_evicted      = r_out_ev;
    assign o_evicted_pid  = r_out_pid;
    assign o_evicted_page = r_out_page;

    a_victim_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVWR) |-> (r_used[r_victim] && r_victim <= n_last))
        else $error("eviction target is not an occupied frame in range");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= n_last))
        else $error("scan pointer passed the last frame in use");

    a_push_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH && r_out_valid && !i_out_ready) |=> (r_state == S_PUSH))
        else $error("result left the sequencer while the output slot was full");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVWR) |=> (!o_in_ready && r_state == S_PUSH))
        else $error("eviction did not hand its result to the output stage");

endmodule

FILE: dv/frame_allocator_lru_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_allocator_lru_checker
// Watches the config, request and result channels of the frame allocator,
// keeps its own copy of the frame table, and compares every result word with
// the oldest predicted one. Reports the mismatch count and the number of
// results still owed.
// ----------------------------------------------------------------------------
module frame_allocator_lru_checker
    import fal_pkg::*;
#(
    parameter int NUM_FRAMES = FAL_NUM_FRAMES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [IDX_W-1:0]   i_frame_index,
    input  logic [PID_W-1:0]   i_owner_pid,
    input  logic [PAGE_W-1:0]  i_virtual_page,
    input  logic [STAMP_W-1:0] i_time_stamp,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic [IDX_W-1:0]   o_result_frame,
    input  logic               o_evicted,
    input  logic [PID_W-1:0]   o_evicted_pid,
    input  logic [PAGE_W-1:0]  o_evicted_page,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic [IDX_W-1:0]  frame;
        logic              evicted;
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
    } frame_result_t;

    logic [CFG_W-1:0]   frame_count;
    logic               frame_busy  [NUM_FRAMES];
    logic [PID_W-1:0]   frame_owner [NUM_FRAMES];
    logic [PAGE_W-1:0]  frame_vpage [NUM_FRAMES];
    logic [STAMP_W-1:0] frame_stamp [NUM_FRAMES];

    frame_result_t owed_results [$];
    int            mismatch_count = 0;
    int            owed_count = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = owed_count;

    // Apply one request to the table copy and return the result word it owes.
    function automatic frame_result_t serve_request(
        input logic [REQ_W-1:0]   kind,
        input logic [IDX_W-1:0]   idx,
        input logic [PID_W-1:0]   pid,
        input logic [PAGE_W-1:0]  vpage,
        input logic [STAMP_W-1:0] stamp
    );
        frame_result_t      res;
        int                 span;
        int                 victim;
        logic [STAMP_W-1:0] oldest;
        bit                 placed;

        span = (frame_count == 0) ? 1 :
               (int'(frame_count) > NUM_FRAMES) ? NUM_FRAMES : int'(frame_count);
        res = '0;
        res.frame = idx;
        case (kind)
            REQ_ALLOC: begin
                placed = 1'b0;
                for (int i = 0; i < span; i++) begin
                    if (!placed && !frame_busy[i]) begin
                        frame_busy[i]  = 1'b1;
                        frame_owner[i] = pid;
                        frame_vpage[i] = vpage;
                        frame_stamp[i] = stamp;
                        res.frame      = IDX_W'(i);
                        placed         = 1'b1;
                    end
                end
                if (!placed) begin
                    // strictly smaller wins: keep the lowest index on ties
                    victim = 0;
                    oldest = frame_stamp[0];
                    for (int i = 1; i < span; i++) begin
                        if (frame_stamp[i] < oldest) begin
                            oldest = frame_stamp[i];
                            victim = i;
                        end
                    end
                    res.frame   = IDX_W'(victim);
                    res.evicted = 1'b1;
                    res.pid     = frame_owner[victim];
                    res.page    = frame_vpage[victim];
                    frame_owner[victim] = pid;
                    frame_vpage[victim] = vpage;
                    frame_stamp[victim] = stamp;
                end
            end
            REQ_FREE: begin
                if (int'(idx) < span) frame_busy[idx] = 1'b0;
            end
            REQ_TOUCH: begin
                if (int'(idx) < span) frame_stamp[idx] = stamp;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        frame_result_t want;
        if (!i_rst_n) begin
            frame_count = CFG_RESET;
            for (int i = 0; i < NUM_FRAMES; i++) frame_busy[i] = 1'b0;
            owed_results.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) frame_count = i_cfg_data;
            if (o_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result word with nothing expected, frame %0d", $time,
                             o_result_frame);
                    mismatch_count++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("result_frame", want.frame, o_result_frame);
                    check_field("evicted", want.evicted, o_evicted);
                    check_field("evicted_pid", want.pid, o_evicted_pid);
                    check_field("evicted_page", want.page, o_evicted_page);
                end
            end
            if (i_in_valid && o_in_ready) begin
                owed_results.push_back(serve_request(i_req_type, i_frame_index,
                                                     i_owner_pid, i_virtual_page,
                                                     i_time_stamp));
            end
        end
        owed_count = owed_results.size();
    end

endmodule

FILE: dv/frame_allocator_lru_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_allocator_lru_test
// Drives request words into the frame allocator over several frame counts:
// a directed run through fill, tie-broken eviction, double free, touch of a
// free frame, out-of-range indexes and the unknown request code, then
// allocation-heavy random traffic with random gaps on both channels and one
// long result stall. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module frame_allocator_lru_test;

    import fal_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 93;
    localparam int LONG_HOLD      = 400;

    typedef struct {
        logic [REQ_W-1:0]   kind;
        logic [IDX_W-1:0]   idx;
        logic [PID_W-1:0]   pid;
        logic [PAGE_W-1:0]  vpage;
        logic [STAMP_W-1:0] stamp;
    } frame_req_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [REQ_W-1:0]   i_req_type = '0;
    logic [IDX_W-1:0]   i_frame_index = '0;
    logic [PID_W-1:0]   i_owner_pid = '0;
    logic [PAGE_W-1:0]  i_virtual_page = '0;
    logic [STAMP_W-1:0] i_time_stamp = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [IDX_W-1:0]   o_result_frame;
    logic               o_evicted;
    logic [PID_W-1:0]   o_evicted_pid;
    logic [PAGE_W-1:0]  o_evicted_page;

    int error_count;
    int owed_count;
    int quiet_cycles = 0;
    int sender_calm = 0;
    int drain_calm = 0;
    int phase_counts [10] = '{32, 1, 63, 0, 7, 40, 2, 17, 31, 3};

    always #1 i_clk = ~i_clk;

    frame_allocator_lru i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_frame_index  (i_frame_index),
        .i_owner_pid    (i_owner_pid),
        .i_virtual_page (i_virtual_page),
        .i_time_stamp   (i_time_stamp),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_frame (o_result_frame),
        .o_evicted      (o_evicted),
        .o_evicted_pid  (o_evicted_pid),
        .o_evicted_page (o_evicted_page)
    );

    frame_allocator_lru_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_frame_index  (i_frame_index),
        .i_owner_pid    (i_owner_pid),
        .i_virtual_page (i_virtual_page),
        .i_time_stamp   (i_time_stamp),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_frame (o_result_frame),
        .o_evicted      (o_evicted),
        .o_evicted_pid  (o_evicted_pid),
        .o_evicted_page (o_evicted_page),
        .o_errors       (error_count),
        .o_pending      (owed_count)
    );

    // Zero gaps for a stretch now and then, otherwise a random wait.
    function automatic int pick_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic frame_req_t make_req(
        input logic [REQ_W-1:0]   kind,
        input logic [IDX_W-1:0]   idx,
        input logic [PID_W-1:0]   pid,
        input logic [PAGE_W-1:0]  vpage,
        input logic [STAMP_W-1:0] stamp
    );
        frame_req_t r;
        r.kind  = kind;
        r.idx   = idx;
        r.pid   = pid;
        r.vpage = vpage;
        r.stamp = stamp;
        return r;
    endfunction

    // Allocation-heavy mix; small stamps make ties common.
    function automatic frame_req_t random_req(input int span);
        frame_req_t r;
        int         pick;
        pick = $urandom_range(0, 99);
        r.kind = (pick < 50) ? REQ_ALLOC : (pick < 70) ? REQ_TOUCH :
                 (pick < 92) ? REQ_FREE : ~REQ_ALLOC;
        r.idx = ($urandom_range(0, 6) == 0) ? IDX_W'($urandom_range(0, 31))
                                            : IDX_W'($urandom_range(0, span - 1));
        r.pid   = PID_W'($urandom);
        r.vpage = PAGE_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 4)      r.stamp = $urandom;
        else if (pick < 8) r.stamp = STAMP_W'($urandom_range(0, 15));
        else if (pick < 9) r.stamp = '1 - STAMP_W'($urandom_range(0, 3));
        else               r.stamp = '0;
        return r;
    endfunction

    task automatic send_frame_req(input frame_req_t r);
        int gap;
        gap = pick_gap(sender_calm);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type     = r.kind;
        i_frame_index  = r.idx;
        i_owner_pid    = r.pid;
        i_virtual_page = r.vpage;
        i_time_stamp   = r.stamp;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and hold until every result word has come back.
    task automatic drain_phase();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (owed_count != 0) @(negedge i_clk);
    endtask

    task automatic set_frame_count(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Result side: random gaps, plus one long hold to back up the request side.
    initial begin
        int gap;
        int taken;
        taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = (taken == 300) ? LONG_HOLD : pick_gap(drain_calm);
            if (gap != 0) begin
                @(negedge i_clk);
                i_out_ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("frame_allocator_lru_test: errors");
                $finish;
            end
        end
    end

    initial begin
        int count;
        int span;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // three frames: fill, ties, double free, touch of a free frame, out of range
        set_frame_count(CFG_W'(3));
        send_frame_req(make_req(REQ_ALLOC, 5'd0, 8'h00, 12'h000, 32'h0000_0000));
        send_frame_req(make_req(REQ_ALLOC, 5'd31, 8'hff, 12'hfff, 32'hffff_ffff));
        send_frame_req(make_req(REQ_ALLOC, 5'd0, 8'h5a, 12'ha5a, 32'h0000_0000));
        send_frame_req(make_req(REQ_ALLOC, 5'd0, 8'h11, 12'h123, 32'h0000_0007));
        send_frame_req(make_req(REQ_TOUCH, 5'd1, 8'h00, 12'h000, 32'h0000_0000));
        send_frame_req(make_req(REQ_ALLOC, 5'd0, 8'h22, 12'h456, 32'h0000_0009));
        send_frame_req(make_req(REQ_FREE, 5'd2, 8'h00, 12'h000, 32'h0000_0000));
        send_frame_req(make_req(REQ_FREE, 5'd2, 8'h00, 12'h000, 32'h0000_0000));
        send_frame_req(make_req(REQ_TOUCH, 5'd2, 8'h00, 12'h000, 32'h0000_0003));
        send_frame_req(make_req(REQ_ALLOC, 5'd0, 8'h33, 12'h789, 32'h0000_0001));
        send_frame_req(make_req(REQ_TOUCH, 5'd31, 8'h00, 12'h000, 32'h0000_0000));
        send_frame_req(make_req(REQ_FREE, 5'd3, 8'h00, 12'h000, 32'h0000_0000));
        send_frame_req(make_req(~REQ_ALLOC, 5'd31, 8'hff, 12'hfff, 32'hffff_ffff));
        send_frame_req(make_req(REQ_ALLOC, 5'd0, 8'h44, 12'habc, 32'h8000_0000));
        send_frame_req(make_req(REQ_FREE, 5'd0, 8'h00, 12'h000, 32'h0000_0000));
        send_frame_req(make_req(REQ_ALLOC, 5'd0, 8'h55, 12'hdef, 32'hffff_ffff));
        send_frame_req(make_req(REQ_TOUCH, 5'd0, 8'h00, 12'h000, 32'hffff_fffe));
        send_frame_req(make_req(~REQ_ALLOC, 5'd0, 8'h00, 12'h000, 32'h0000_0000));
        send_frame_req(make_req(REQ_ALLOC, 5'd0, 8'h66, 12'h001, 32'h0000_0002));
        drain_phase();

        foreach (phase_counts[p]) begin
            count = phase_counts[p];
            span  = (count == 0) ? 1 : (count > FAL_NUM_FRAMES) ? FAL_NUM_FRAMES : count;
            set_frame_count(CFG_W'(count));
            repeat (PHASE_ITEMS) send_frame_req(random_req(span));
            drain_phase();
        end

        // let any stray result word show up before the verdict
        repeat (50) @(negedge i_clk);
        if (error_count == 0 && owed_count == 0) begin
            $display("frame_allocator_lru_test: clean");
        end else begin
            $display("frame_allocator_lru_test: errors");
        end
        $finish;
    end

endmodule
